// File: rtl/core/rpt_pkg.sv
// Shared types and constants for the radar pass tracker.
package rpt_pkg;

  localparam int SlotW  = 3;
  localparam int BinW   = 9;
  localparam int LevelW = 16;
  localparam int TrackW = 8;
  localparam int ConfW  = 4;
  localparam int PhaseW = 3;
  localparam int EventW = 16;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;

  localparam int Bins = 512;

  localparam logic [TrackW-1:0] FoundTracks  = 8'd2;
  localparam logic [ConfW-1:0]  NeededReset  = 4'd2;
  localparam logic [ConfW-1:0]  CapReset     = 4'd10;

  typedef enum logic [PhaseW-1:0] {
    PhWait     = 3'd0,
    PhFound    = 3'd1,
    PhApproach = 3'd2,
    PhFront    = 3'd3,
    PhRecede   = 3'd4,
    PhCount    = 3'd5
  } phase_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgMinBin    = 3'd0,
    CfgMinLevel  = 3'd1,
    CfgMinTracks = 3'd2,
    CfgCutoffBin = 3'd3,
    CfgConfNeed  = 3'd4,
    CfgConfCap   = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    phase_e              phase;
    logic [ConfW-1:0]    bin_conf;
    logic [ConfW-1:0]    lvl_conf;
    logic [BinW-1:0]     last_bin;
    logic [LevelW-1:0]   last_lvl;
  } entry_t;

endpackage

// File: rtl/core/rpt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rpt_ram #(
  parameter int WIDTH = 36,
  parameter int DEPTH = 8
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/radar_pass_tracker.sv
// Radar pass tracker: per-slot pass phase machine over a slot state RAM.
// Path: RAM read register, then output register; one transaction per cycle unless
// out_stall_i holds a result; same-slot back-to-back updates use a write forward.
// Reset: config to defaults, event counter zero, per-slot valid bits cleared at once
// so every slot reads as waiting with zero state; no clearing pass.
module radar_pass_tracker
  import rpt_pkg::*;
#(
  parameter int SLOTS = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [SlotW-1:0]    slot_i,
  input  logic                entry_valid_i,
  input  logic [BinW-1:0]     peak_bin_i,
  input  logic [LevelW-1:0]   peak_level_i,
  input  logic [TrackW-1:0]   track_count_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [SlotW-1:0]    slot_out_o,
  output logic [PhaseW-1:0]   phase_o,
  output logic                counted_o,
  output logic [EventW-1:0]   event_total_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int AddrW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int SlotExtW = AddrW + SlotW;
  localparam int EntryW   = $bits(entry_t);

  function automatic logic [ConfW-1:0] conf_move(logic [ConfW-1:0] c, logic up,
                                                 logic [ConfW-1:0] cap);
    logic [ConfW-1:0] r;
    r = c;
    if (up) begin
      if (c < cap) r = c + 1'b1;
    end else if (c != '0) begin
      r = c - 1'b1;
    end
    return r;
  endfunction

  // configuration
  logic [BinW-1:0]   min_bin_q, cutoff_bin_q;
  logic [LevelW-1:0] min_lvl_q;
  logic [TrackW-1:0] min_trk_q;
  logic [ConfW-1:0]  need_q, cap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_bin_q    <= '0;
      min_lvl_q    <= '0;
      min_trk_q    <= '0;
      cutoff_bin_q <= '0;
      need_q       <= NeededReset;
      cap_q        <= CapReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CfgMinBin:    min_bin_q    <= cfg_data_i[BinW-1:0];
        CfgMinLevel:  min_lvl_q    <= cfg_data_i[LevelW-1:0];
        CfgMinTracks: min_trk_q    <= cfg_data_i[TrackW-1:0];
        CfgCutoffBin: cutoff_bin_q <= cfg_data_i[BinW-1:0];
        CfgConfNeed:  need_q       <= cfg_data_i[ConfW-1:0];
        CfgConfCap:   cap_q        <= cfg_data_i[ConfW-1:0];
        default: ;
      endcase
    end
  end

  // input decode
  logic [SlotExtW-1:0] in_slot_ext;
  logic [AddrW-1:0]    in_addr;
  logic                in_range;
  logic [BinW-1:0]     in_bin;
  logic                in_acc;

  assign in_slot_ext = {{AddrW{1'b0}}, slot_i};
  assign in_addr     = in_slot_ext[AddrW-1:0];
  assign in_range    = in_slot_ext < SlotExtW'(SLOTS);
  assign in_bin      = (32'(peak_bin_i) >= Bins) ? BinW'(Bins - 1) : peak_bin_i;

  // pipeline control
  logic s1_vld_q, out_vld_q, s1_adv;

  assign s1_adv     = s1_vld_q && !(out_vld_q && out_stall_i);
  assign in_stall_o = s1_vld_q && !s1_adv;
  assign in_acc     = in_valid_i && !in_stall_o;

  // stage 1 registers
  logic [SlotW-1:0]   s1_slot_q;
  logic [AddrW-1:0]   s1_addr_q;
  logic               s1_range_q, s1_ev_q;
  logic [BinW-1:0]    s1_bin_q;
  logic [LevelW-1:0]  s1_lvl_q;
  logic [TrackW-1:0]  s1_trk_q;
  logic               rd_vld_q, fwd_hit_q;
  entry_t             fwd_data_q;

  logic [SLOTS-1:0]   vld_q;
  logic [EventW-1:0]  evt_q, evt_d;

  logic               wr_en;
  entry_t             wr_data;
  logic [EntryW-1:0]  rd_raw;
  entry_t             cur, nxt;
  logic               bump, qual, res_bump;
  phase_e             res_phase;
  logic [ConfW-1:0]   bc, lc;

  rpt_ram #(
    .WIDTH(EntryW),
    .DEPTH(SLOTS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(s1_addr_q),
    .wdata_i(wr_data),
    .re_i   (in_acc),
    .raddr_i(in_addr),
    .rdata_o(rd_raw)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      rd_vld_q  <= 1'b0;
      fwd_hit_q <= 1'b0;
      vld_q     <= '0;
    end else begin
      if (in_acc) begin
        s1_vld_q  <= 1'b1;
        rd_vld_q  <= vld_q[in_addr];
        fwd_hit_q <= wr_en && (s1_addr_q == in_addr);
      end else if (s1_adv) begin
        s1_vld_q  <= 1'b0;
      end
      if (wr_en) begin
        vld_q[s1_addr_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_slot_q  <= slot_i;
      s1_addr_q  <= in_addr;
      s1_range_q <= in_range;
      s1_ev_q    <= entry_valid_i;
      s1_bin_q   <= in_bin;
      s1_lvl_q   <= peak_level_i;
      s1_trk_q   <= track_count_i;
      fwd_data_q <= wr_data;
    end
  end

  // read-modify-write
  always_comb begin
    if (fwd_hit_q) begin
      cur = fwd_data_q;
    end else if (rd_vld_q) begin
      cur = entry_t'(rd_raw);
    end else begin
      cur = '0;
    end

    qual = s1_ev_q && (s1_bin_q > min_bin_q) && (s1_lvl_q > min_lvl_q) &&
           (s1_trk_q > min_trk_q);
    nxt  = cur;
    bump = 1'b0;
    bc   = '0;
    lc   = '0;

    if (qual) begin
      unique case (cur.phase)
        PhFound: begin
          bc = conf_move(cur.bin_conf, s1_bin_q <= cur.last_bin, cap_q);
          lc = conf_move(cur.lvl_conf, s1_lvl_q >= cur.last_lvl, cap_q);
          nxt.bin_conf = bc;
          nxt.lvl_conf = lc;
          if (bc > need_q && lc > need_q) begin
            nxt.phase = PhApproach;
            bump      = 1'b1;
          end
        end
        PhApproach: begin
          if (s1_bin_q <= cutoff_bin_q) begin
            nxt.phase = PhFront;
            bump      = 1'b1;
          end
        end
        PhFront: begin
          nxt.bin_conf = '0;
          nxt.lvl_conf = '0;
          if (s1_bin_q > cutoff_bin_q) nxt.phase = PhRecede;
        end
        PhRecede: begin
          bc = conf_move(cur.bin_conf, s1_bin_q >= cur.last_bin, cap_q);
          lc = conf_move(cur.lvl_conf, s1_lvl_q <= cur.last_lvl, cap_q);
          nxt.bin_conf = bc;
          nxt.lvl_conf = lc;
          if (bc > need_q && lc > need_q) nxt.phase = PhCount;
        end
        PhCount: begin
          nxt.phase = PhWait;
          bump      = 1'b1;
        end
        default: begin
          nxt.phase = (s1_trk_q > FoundTracks) ? PhFound : PhWait;
        end
      endcase
      nxt.last_bin = s1_bin_q;
      nxt.last_lvl = s1_lvl_q;
    end else begin
      nxt.phase    = PhWait;
      nxt.bin_conf = '0;
      nxt.lvl_conf = '0;
    end
  end

  assign wr_en     = s1_adv && s1_range_q;
  assign wr_data   = nxt;
  assign res_phase = s1_range_q ? nxt.phase : PhWait;
  assign res_bump  = s1_range_q && bump;
  assign evt_d     = (s1_adv && res_bump) ? evt_q + 1'b1 : evt_q;

  // output register
  logic [SlotW-1:0]  out_slot_q;
  phase_e            out_phase_q;
  logic              out_cnt_q;
  logic [EventW-1:0] out_evt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      evt_q     <= '0;
    end else begin
      evt_q     <= evt_d;
      out_vld_q <= s1_adv || (out_vld_q && out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_slot_q  <= s1_slot_q;
      out_phase_q <= res_phase;
      out_cnt_q   <= res_bump;
      out_evt_q   <= evt_d;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign slot_out_o    = out_slot_q;
  assign phase_o       = out_phase_q;
  assign counted_o     = out_cnt_q;
  assign event_total_o = out_evt_q;

`ifndef NO_ASSERTIONS
  a_stall_only_when_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_vld_q && out_vld_q && out_stall_i))
    else $error("input stalled without a blocked result");

  a_count_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && res_bump) |=> (evt_q == $past(evt_q) + 1'b1))
    else $error("event counter did not advance by one");

  a_count_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_cnt_q) |->
      (out_phase_q == PhApproach || out_phase_q == PhFront || out_phase_q == PhWait))
    else $error("counted result in a phase that never counts");

  a_no_write_out_of_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && !s1_range_q) |-> (!res_bump && res_phase == PhWait))
    else $error("out-of-range slot changed state");
`endif

endmodule
